>>> rtl/pat_pkg.sv
// Shared types, widths and command codes for the point affine transform.
// Used by pat_matrix, pat_dot and point_affine_transform.
`default_nettype none

package pat_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int ROW_COLS    = 4;
  localparam int ROW_COUNT   = 3;
  localparam int ROW_ENTRIES = ROW_COUNT * ROW_COLS;
  localparam int INDEX_WIDTH = 4;

  // A product of two coordinates, the sum of four products, and that sum after the
  // fraction bits are dropped.
  localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int SHIFT_WIDTH = SUM_WIDTH - FRAC_BITS;

  localparam int IN_FIELDS_WIDTH = INDEX_WIDTH + 4 * COORD_WIDTH;
  localparam int IN_DATA_WIDTH   = ((IN_FIELDS_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_WIDTH  = ((ROW_COUNT * COORD_WIDTH + 7) / 8) * 8;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_XFORM = 1'b1;

  typedef logic [COORD_WIDTH-1:0]                  coord_t;
  typedef logic [ROW_COLS-1:0][COORD_WIDTH-1:0]    row_t;
  typedef logic [ROW_ENTRIES-1:0][COORD_WIDTH-1:0] matrix_t;
  typedef logic signed [SHIFT_WIDTH-1:0]           shifted_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } dot_en_t;

  // True when the shifted sum does not fit a signed coordinate.
  function automatic logic coord_over(input shifted_t v);
    logic [SHIFT_WIDTH-COORD_WIDTH:0] hi;
    hi = v[SHIFT_WIDTH-1:COORD_WIDTH-1];
    return (|hi) && !(&hi);
  endfunction

  function automatic coord_t coord_clamp(input shifted_t v);
    coord_t r;
    if (coord_over(v)) begin
      r = {v[SHIFT_WIDTH-1], {(COORD_WIDTH-1){~v[SHIFT_WIDTH-1]}}};
    end else begin
      r = v[COORD_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/point_affine_transform.sv
// Top level of the affine vertex transform: stream ports, stage control, saturation.
// Depends on pat_pkg, pat_matrix and pat_dot.
//
//   port group  dir  tdata fields (low bit up)                         tuser
//   s_*         in   elem_index, elem_value, point_x, point_y, point_z  cmd
//   m_*         out  out_x, out_y, out_z                                saturated
//
// One transaction per clock on s_* while s_tready is high. A transform is registered in
// order: multiply at the transaction edge, then pair sums, final sum with floor shift,
// clamp into the output register. A load writes the matrix at its transaction
// and yields nothing; later transforms see it, earlier ones in flight do not.
// Reset restores the identity matrix and empties the pipeline.
// Each stage holds only while it is full and the next one holds, so bubbles close up.
`default_nettype none

module point_affine_transform (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // elem_index, elem_value, point_x, point_y, point_z, zero pad
  input  wire  [pat_pkg::IN_DATA_WIDTH-1:0]   s_tdata,
  // cmd
  input  wire                                 s_tuser,
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // out_x, out_y, out_z
  output logic [pat_pkg::OUT_DATA_WIDTH-1:0]  m_tdata,
  // saturated
  output logic                                m_tuser
);
  import pat_pkg::*;

  localparam int IDX_LO = 0;
  localparam int VAL_LO = IDX_LO + INDEX_WIDTH;
  localparam int PX_LO  = VAL_LO + COORD_WIDTH;
  localparam int PY_LO  = PX_LO + COORD_WIDTH;
  localparam int PZ_LO  = PY_LO + COORD_WIDTH;

  logic [INDEX_WIDTH-1:0] elem_index;
  coord_t                 elem_value, point_x, point_y, point_z;
  logic                   accept;
  matrix_t                mat;
  dot_en_t                en;
  logic                   valid1, valid2, valid3;
  logic                   ready1, ready2, ready3, ready4;
  shifted_t               shifted [ROW_COUNT];
  coord_t                 clamped [ROW_COUNT];
  logic [ROW_COUNT-1:0]   over;

  assign elem_index = s_tdata[IDX_LO +: INDEX_WIDTH];
  assign elem_value = s_tdata[VAL_LO +: COORD_WIDTH];
  assign point_x    = s_tdata[PX_LO +: COORD_WIDTH];
  assign point_y    = s_tdata[PY_LO +: COORD_WIDTH];
  assign point_z    = s_tdata[PZ_LO +: COORD_WIDTH];

  // a stage may load when empty or when the next stage moves
  assign ready4   = !m_tvalid || m_tready;
  assign ready3   = !valid3 || ready4;
  assign ready2   = !valid2 || ready3;
  assign ready1   = !valid1 || ready2;
  assign s_tready = ready1;
  assign accept   = s_tvalid && ready1;

  assign en.s1 = ready1;
  assign en.s2 = ready2;
  assign en.s3 = ready3;

  pat_matrix u_matrix (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept && (s_tuser == CMD_LOAD)),
    .wr_index (elem_index),
    .wr_value (elem_value),
    .mat      (mat)
  );

  for (genvar r = 0; r < ROW_COUNT; r++) begin : g_row
    pat_dot u_dot (
      .clk     (clk),
      .en      (en),
      .row     (mat[r*ROW_COLS +: ROW_COLS]),
      .px      (point_x),
      .py      (point_y),
      .pz      (point_z),
      .shifted (shifted[r])
    );
    assign clamped[r] = coord_clamp(shifted[r]);
    assign over[r]    = coord_over(shifted[r]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1   <= 1'b0;
      valid2   <= 1'b0;
      valid3   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (ready1) begin
        valid1 <= s_tvalid && (s_tuser == CMD_XFORM);
      end
      if (ready2) begin
        valid2 <= valid1;
      end
      if (ready3) begin
        valid3 <= valid2;
      end
      if (ready4) begin
        m_tvalid <= valid3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      m_tdata <= OUT_DATA_WIDTH'({clamped[2], clamped[1], clamped[0]});
      m_tuser <= |over;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pat_matrix.sv
// Matrix store: top three rows of the 4x4 transform, reset to identity.
// Depends on pat_pkg for widths and types.
`default_nettype none

module pat_matrix (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                wr_en,
  input  wire  [pat_pkg::INDEX_WIDTH-1:0]    wr_index,
  input  wire  pat_pkg::coord_t              wr_value,
  output pat_pkg::matrix_t                   mat
);
  import pat_pkg::*;

  matrix_t entries;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROW_ENTRIES; i++) begin
        if (i % (ROW_COLS + 1) == 0) begin
          entries[i] <= COORD_WIDTH'(1) << FRAC_BITS;
        end else begin
          entries[i] <= '0;
        end
      end
    end else if (wr_en && (32'(wr_index) < ROW_ENTRIES)) begin
      // indexes past the last row are dropped
      entries[wr_index] <= wr_value;
    end
  end

  assign mat = entries;

endmodule

`default_nettype wire

>>> rtl/pat_dot.sv
// One row dot product in three stages: multiply, pair sums, final sum and floor shift.
// Depends on pat_pkg for widths, row type and stage enables.
`default_nettype none

module pat_dot (
  input  wire                     clk,
  input  wire  pat_pkg::dot_en_t  en,
  input  wire  pat_pkg::row_t     row,
  input  wire  pat_pkg::coord_t   px,
  input  wire  pat_pkg::coord_t   py,
  input  wire  pat_pkg::coord_t   pz,
  output pat_pkg::shifted_t       shifted
);
  import pat_pkg::*;

  logic signed [PROD_WIDTH-1:0] prod_x, prod_y, prod_z, prod_w;
  logic signed [SUM_WIDTH-1:0]  sum_a, sum_b;
  logic signed [SUM_WIDTH-1:0]  sum_all;
  shifted_t                     shifted_reg;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod_x <= $signed(row[0]) * $signed(px);
      prod_y <= $signed(row[1]) * $signed(py);
      prod_z <= $signed(row[2]) * $signed(pz);
      // translation column times w = 1.0
      prod_w <= $signed({{(PROD_WIDTH-COORD_WIDTH){row[3][COORD_WIDTH-1]}}, row[3]})
                <<< FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum_a <= SUM_WIDTH'(prod_x) + SUM_WIDTH'(prod_y);
      sum_b <= SUM_WIDTH'(prod_z) + SUM_WIDTH'(prod_w);
    end
  end

  assign sum_all = sum_a + sum_b;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      shifted_reg <= SHIFT_WIDTH'(sum_all >>> FRAC_BITS);
    end
  end

  assign shifted = shifted_reg;

endmodule

`default_nettype wire

>>> verif/tb_point_affine_transform.sv
// Self-checking testbench for point_affine_transform: matrix loads and point transforms
// on the s_* stream, results on m_* compared with a Q16.16 predictor kept here.
// Depends on pat_pkg and the RTL of point_affine_transform.
module tb_point_affine_transform;
  import pat_pkg::*;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } point_result_t;

  localparam logic signed [79:0] COORD_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] COORD_MIN = -80'sd2147483648;
  localparam coord_t Q_ONE = coord_t'(1) << FRAC_BITS;
  localparam int     DRAIN_CYCLES = 20;

  logic                      clk;
  logic                      rst;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [IN_DATA_WIDTH-1:0]  s_tdata;
  logic                      s_tuser;
  logic                      m_tvalid;
  logic                      m_tready;
  logic [OUT_DATA_WIDTH-1:0] m_tdata;
  logic                      m_tuser;

  coord_t        matrix_shadow [ROW_ENTRIES];
  point_result_t pending_points [$];
  int            mismatch_count = 0;
  int            src_gap_pct    = 0;
  int            sink_stall_pct = 0;

  point_affine_transform dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** point_affine_transform: FAILED **");
    $finish;
  end

  // Exact dot product of each row with (x, y, z, 1.0), floor shift, clamp.
  function automatic point_result_t transform_point(coord_t px, coord_t py, coord_t pz);
    point_result_t      res;
    logic signed [79:0] acc;
    coord_t             pt [3];
    coord_t             lane [3];
    pt = '{px, py, pz};
    res.sat = 1'b0;
    for (int r = 0; r < ROW_COUNT; r++) begin
      acc = $signed(matrix_shadow[r*ROW_COLS+3]) <<< FRAC_BITS;
      for (int c = 0; c < 3; c++) begin
        acc = acc + $signed(matrix_shadow[r*ROW_COLS+c]) * $signed(pt[c]);
      end
      acc = acc >>> FRAC_BITS;
      if (acc > COORD_MAX) begin
        acc = COORD_MAX;
        res.sat = 1'b1;
      end else if (acc < COORD_MIN) begin
        acc = COORD_MIN;
        res.sat = 1'b1;
      end
      lane[r] = acc[COORD_WIDTH-1:0];
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  function automatic void reset_matrix_shadow();
    foreach (matrix_shadow[i]) matrix_shadow[i] = '0;
    matrix_shadow[0]  = Q_ONE;
    matrix_shadow[5]  = Q_ONE;
    matrix_shadow[10] = Q_ONE;
  endfunction

  // Mostly small Q16.16 values so sums stay in range, with extremes and full-range noise.
  function automatic coord_t rand_coord();
    coord_t v;
    case ($urandom_range(9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = '1;
          default: v = 32'h0000_0001;
        endcase
      end
      default: v = coord_t'(int'($urandom_range(2**21 - 1)) - 2**20);
    endcase
    return v;
  endfunction

  // Send one transaction; predict at acceptance so loads apply in stream order.
  task automatic send_item(logic cmd, logic [INDEX_WIDTH-1:0] idx, coord_t val,
                           coord_t px, coord_t py, coord_t pz);
    while ($urandom_range(99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_WIDTH'({pz, py, px, val, idx});
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_XFORM) begin
      pending_points.push_back(transform_point(px, py, pz));
    end else if (idx < ROW_ENTRIES) begin
      matrix_shadow[idx] = val;
    end
  endtask

  task automatic load_entry(int idx, coord_t val);
    send_item(CMD_LOAD, idx[INDEX_WIDTH-1:0], val, $urandom, $urandom, $urandom);
  endtask

  task automatic xform(coord_t px, coord_t py, coord_t pz);
    send_item(CMD_XFORM, 4'($urandom), $urandom, px, py, pz);
  endtask

  task automatic test_reset_identity();
    xform(32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000);
    xform(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
  endtask

  task automatic test_matrix_load();
    coord_t rows [ROW_ENTRIES];
    rows = '{32'h0002_0000, 32'hFFFF_8000, 32'h0000_4000, 32'h000A_0000,
             32'h0000_0000, 32'hFFFF_0000, 32'h0003_0000, 32'hFFF8_8000,
             32'h0000_2000, 32'h0000_0000, 32'h0001_0000, 32'hFF9C_0000};
    foreach (rows[i]) load_entry(i, rows[i]);
    xform(32'hFFFE_A001, 32'h0004_3333, 32'hFFFF_FFFF);
  endtask

  // Indexes past the last row must leave the matrix alone.
  task automatic test_ignored_index();
    load_entry(12, 32'h7FFF_FFFF);
    load_entry(13, 32'h8000_0000);
    load_entry(15, $urandom);
    xform(32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000);
  endtask

  task automatic test_saturation();
    load_entry(0, 32'h7FFF_FFFF);
    load_entry(4, 32'h8000_0000);
    xform(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
  endtask

  // A product of -1 LSB must floor to -1, not truncate toward zero.
  task automatic test_floor_rounding();
    load_entry(0, 32'h0000_0001);
    xform(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    xform(32'h0000_FFFF, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random_stream(int count, int gap_pct, int stall_pct);
    src_gap_pct    = gap_pct;
    sink_stall_pct = stall_pct;
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        send_item(CMD_LOAD, 4'($urandom_range(15)), rand_coord(),
                  $urandom, $urandom, $urandom);
      end else begin
        send_item(CMD_XFORM, 4'($urandom), $urandom,
                  rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_result
    point_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_points.size() == 0) begin
        $error("result with none pending: tdata %h tuser %b", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = pending_points.pop_front();
        if (m_tdata[31:0] !== want.x) begin
          $error("out_x: expected %h, got %h", want.x, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[63:32] !== want.y) begin
          $error("out_y: expected %h, got %h", want.y, m_tdata[63:32]);
          mismatch_count++;
        end
        if (m_tdata[95:64] !== want.z) begin
          $error("out_z: expected %h, got %h", want.z, m_tdata[95:64]);
          mismatch_count++;
        end
        if (m_tuser !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, m_tuser);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_LOAD;
    m_tready = 1'b0;
    reset_matrix_shadow();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_identity();
    test_matrix_load();
    test_ignored_index();
    test_saturation();
    test_floor_rounding();
    test_random_stream(584, 16, 79);
    test_random_stream(584, 79, 16);
    test_random_stream(584, 0, 0);
    s_tvalid <= 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** point_affine_transform: PASSED **");
    end else begin
      $display("** point_affine_transform: FAILED **");
    end
    $finish;
  end

endmodule
